// ===== rtl/core/rhbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbb_pkg
// Shared types and constants of the projective bounding box unit.
// ----------------------------------------------------------------------------
package rhbb_pkg;

	localparam int COEF_W   = 32;
	localparam int BOX_W    = 32;
	localparam int EXT_W    = 31;
	localparam int NUM_COEF = 9;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0_AB     = 3'd0,
		CFG_ROW0C_ROW1A = 3'd1,
		CFG_ROW1_BC     = 3'd2,
		CFG_ROW2_AB     = 3'd3,
		CFG_ROW2_C      = 3'd4
	} cfg_idx_t;

	// travels alongside each item down the pipeline
	typedef struct packed {
		logic valid;
		logic empty;
	} tag_t;

endpackage

// ===== rtl/core/rhbb_corner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbb_corner
// Maps one corner through the matrix: products, then sums with zero-w fix.
// ----------------------------------------------------------------------------
module rhbb_corner #(
	parameter int PW   = 17,
	parameter int NW   = 51,
	parameter int FRAC = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [PW-1:0] px,
	input  logic signed [PW-1:0] py,
	input  rhbb_pkg::coef_t      m [0:rhbb_pkg::NUM_COEF-1],
	output logic signed [NW-1:0] nx,
	output logic signed [NW-1:0] ny,
	output logic signed [NW-1:0] w
);

	localparam int PRW = PW + rhbb_pkg::COEF_W;
	localparam logic signed [NW-1:0] W_ONE = $signed(NW'(1) << FRAC);

	logic signed [PRW-1:0] prod_s1 [0:5];
	logic signed [NW-1:0]  w_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= m[0] * px;
			prod_s1[1] <= m[1] * py;
			prod_s1[2] <= m[3] * px;
			prod_s1[3] <= m[4] * py;
			prod_s1[4] <= m[6] * px;
			prod_s1[5] <= m[7] * py;
		end
	end

	assign w_sum = NW'(prod_s1[4]) + NW'(prod_s1[5]) + NW'(m[8]);

	always_ff @(posedge clk) begin
		if (en) begin
			nx <= NW'(prod_s1[0]) + NW'(prod_s1[1]) + NW'(m[2]);
			ny <= NW'(prod_s1[2]) + NW'(prod_s1[3]) + NW'(m[5]);
			w  <= (w_sum == '0) ? W_ONE : w_sum;
		end
	end

endmodule

// ===== rtl/core/rhbb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbb_div
// Pipelined restoring divider lane, one quotient bit per stage,
// giving both floor and ceil of n / d.
// ----------------------------------------------------------------------------
module rhbb_div #(
	parameter int NW = 51
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [NW-1:0] n,
	input  logic signed [NW-1:0] d,
	output logic signed [NW:0]   q_floor,
	output logic signed [NW:0]   q_ceil
);

	logic [NW-1:0] rem_s [0:NW];
	logic [NW-1:0] num_s [0:NW];
	logic [NW-1:0] den_s [0:NW-1];
	logic          neg_s [0:NW];
	logic signed [NW:0] q_mag;
	logic signed [NW:0] q_inc;

	// magnitudes; the most negative value maps onto its own unsigned pattern
	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= n[NW-1] ? NW'(-n) : NW'(n);
			den_s[0] <= d[NW-1] ? NW'(-d) : NW'(d);
			rem_s[0] <= '0;
			neg_s[0] <= n[NW-1] ^ d[NW-1];
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [NW:0] trial;
		logic        ge;
		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign ge    = trial >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NW'(trial - {1'b0, den_s[k]}) : trial[NW-1:0];
				num_s[k+1] <= {num_s[k][NW-2:0], ge};
				neg_s[k+1] <= neg_s[k];
			end
		end
		if (k < NW - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign q_mag = $signed({1'b0, num_s[NW]});
	assign q_inc = $signed({{NW{1'b0}}, |rem_s[NW]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NW]) begin
				q_floor <= -q_mag - q_inc;
				q_ceil  <= -q_mag;
			end else begin
				q_floor <= q_mag;
				q_ceil  <= q_mag + q_inc;
			end
		end
	end

endmodule

// ===== rtl/core/rhbb_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbb_reduce
// Min/max over the four corners, clipping, extents and empty test.
// ----------------------------------------------------------------------------
module rhbb_reduce #(
	parameter int VW = 52
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  rhbb_pkg::tag_t        tag_in,
	input  logic signed [VW-1:0]  fx [0:3],
	input  logic signed [VW-1:0]  cx [0:3],
	input  logic signed [VW-1:0]  fy [0:3],
	input  logic signed [VW-1:0]  cy [0:3],
	output rhbb_pkg::tag_t        tag_out,
	output logic [rhbb_pkg::BOX_W-1:0] box_x,
	output logic [rhbb_pkg::BOX_W-1:0] box_y,
	output logic [rhbb_pkg::EXT_W-1:0] box_width,
	output logic [rhbb_pkg::EXT_W-1:0] box_height,
	output logic                  box_empty,
	output logic                  saturated
);

	localparam int BW = rhbb_pkg::BOX_W;
	localparam logic signed [VW-1:0] CLIP_HI = VW'(64'sd2147483647);
	localparam logic signed [VW-1:0] CLIP_LO = VW'(-64'sd2147483648);

	function automatic logic [BW:0] clip(input logic signed [VW-1:0] v);
		logic [BW:0] r;
		if (v > CLIP_HI) begin
			r = {1'b1, 1'b0, {(BW-1){1'b1}}};
		end else if (v < CLIP_LO) begin
			r = {1'b1, 1'b1, {(BW-1){1'b0}}};
		end else begin
			r = {1'b0, v[BW-1:0]};
		end
		return r;
	endfunction

	rhbb_pkg::tag_t tag_s1, tag_s2;
	logic signed [VW-1:0] xlo_s1 [0:1], xhi_s1 [0:1], ylo_s1 [0:1], yhi_s1 [0:1];
	logic signed [VW-1:0] xmin_s2, xmax_s2, ymin_s2, ymax_s2;
	logic [BW:0]          cl_x0, cl_y0, cl_x1, cl_y1;
	logic signed [BW:0]   ext_w, ext_h;
	logic                 degen, sat_any, wide_w, wide_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_out <= '0;
		end else if (en) begin
			tag_s1  <= tag_in;
			tag_s2  <= tag_s1;
			tag_out <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				xlo_s1[i] <= (fx[2*i] < fx[2*i+1]) ? fx[2*i] : fx[2*i+1];
				xhi_s1[i] <= (cx[2*i] > cx[2*i+1]) ? cx[2*i] : cx[2*i+1];
				ylo_s1[i] <= (fy[2*i] < fy[2*i+1]) ? fy[2*i] : fy[2*i+1];
				yhi_s1[i] <= (cy[2*i] > cy[2*i+1]) ? cy[2*i] : cy[2*i+1];
			end
			xmin_s2 <= (xlo_s1[0] < xlo_s1[1]) ? xlo_s1[0] : xlo_s1[1];
			xmax_s2 <= (xhi_s1[0] > xhi_s1[1]) ? xhi_s1[0] : xhi_s1[1];
			ymin_s2 <= (ylo_s1[0] < ylo_s1[1]) ? ylo_s1[0] : ylo_s1[1];
			ymax_s2 <= (yhi_s1[0] > yhi_s1[1]) ? yhi_s1[0] : yhi_s1[1];
		end
	end

	always_comb begin
		cl_x0   = clip(xmin_s2);
		cl_y0   = clip(ymin_s2);
		cl_x1   = clip(xmax_s2);
		cl_y1   = clip(ymax_s2);
		ext_w   = $signed({cl_x1[BW-1], cl_x1[BW-1:0]}) - $signed({cl_x0[BW-1], cl_x0[BW-1:0]});
		ext_h   = $signed({cl_y1[BW-1], cl_y1[BW-1:0]}) - $signed({cl_y0[BW-1], cl_y0[BW-1:0]});
		degen   = (ext_w <= 0) || (ext_h <= 0);
		wide_w  = ext_w[BW-1];
		wide_h  = ext_h[BW-1];
		sat_any = cl_x0[BW] | cl_y0[BW] | cl_x1[BW] | cl_y1[BW] | wide_w | wide_h;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tag_s2.empty || degen) begin
				box_x      <= '0;
				box_y      <= '0;
				box_width  <= '0;
				box_height <= '0;
				box_empty  <= 1'b1;
				saturated  <= 1'b0;
			end else begin
				box_x      <= cl_x0[BW-1:0];
				box_y      <= cl_y0[BW-1:0];
				box_width  <= wide_w ? {(BW-1){1'b1}} : ext_w[BW-2:0];
				box_height <= wide_h ? {(BW-1){1'b1}} : ext_h[BW-2:0];
				box_empty  <= 1'b0;
				saturated  <= sat_any;
			end
		end
	end

endmodule

// ===== rtl/core/rect_homography_bounding_box_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_homography_bounding_box_unit
// Projective bounding box of an integer rectangle under a Q-format 3x3 matrix.
// ----------------------------------------------------------------------------
//  channel   direction  signals                               content
//  s_axis    in         tvalid tready tdata                   rect_x, rect_y, rect_width, rect_height
//  m_axis    out        tvalid tready tdata tuser             box x/y/width/height; empty, saturated
//  cfg       in         cfg_valid cfg_ready cfg_index cfg_data coefficient register writes
//
//  one rectangle per cycle while the pipeline is not held; a result's delay after its request is
//  set mostly by the COORD_WIDTH + 35 quotient-bit stages of the dividers.
//  the whole pipeline holds while a result waits on m_axis_tready.
//  reset clears all valid bits and loads the identity matrix.
//  cfg_ready is always high; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module rect_homography_bounding_box_unit #(
	parameter int COORD_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// rect_x, rect_y, rect_width, rect_height, zero fill
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// box_x[31:0], box_y[63:32], box_width[94:64], box_height[125:95], zero fill
	output logic [127:0] m_axis_tdata,
	// box_empty, saturated
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [rhbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int CW  = COORD_WIDTH;
	localparam int PW  = CW + 1;
	localparam int NW  = CW + 35;
	localparam int VW  = NW + 1;
	localparam int DLY = NW + 4;
	localparam logic [63:0] ONE_HI = 64'(1) << (COEF_FRAC_BITS + 32);
	localparam logic [31:0] ONE_LO = 32'(1) << COEF_FRAC_BITS;

	logic [63:0] row0_ab_q, row0c_row1a_q, row1_bc_q, row2_ab_q;
	logic [31:0] row2_c_q;
	rhbb_pkg::coef_t m [0:rhbb_pkg::NUM_COEF-1];

	logic adv;
	rhbb_pkg::tag_t tag_d [0:DLY];
	rhbb_pkg::tag_t tag_out;
	logic signed [CW-1:0] rx_s1, ry_s1, rw_s1, rh_s1;
	logic signed [NW-1:0] nx [0:3], ny [0:3], wv [0:3];
	logic signed [VW-1:0] fx [0:3], cx [0:3], fy [0:3], cy [0:3];
	logic [rhbb_pkg::BOX_W-1:0] box_x, box_y;
	logic [rhbb_pkg::EXT_W-1:0] box_width, box_height;
	logic box_empty, saturated;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_ab_q     <= ONE_HI;
			row0c_row1a_q <= '0;
			row1_bc_q     <= ONE_HI;
			row2_ab_q     <= '0;
			row2_c_q      <= ONE_LO;
		end else if (cfg_valid) begin
			case (rhbb_pkg::cfg_idx_t'(cfg_index))
				rhbb_pkg::CFG_ROW0_AB:     row0_ab_q     <= cfg_data;
				rhbb_pkg::CFG_ROW0C_ROW1A: row0c_row1a_q <= cfg_data;
				rhbb_pkg::CFG_ROW1_BC:     row1_bc_q     <= cfg_data;
				rhbb_pkg::CFG_ROW2_AB:     row2_ab_q     <= cfg_data;
				rhbb_pkg::CFG_ROW2_C:      row2_c_q      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign m[0] = row0_ab_q[63:32];
	assign m[1] = row0_ab_q[31:0];
	assign m[2] = row0c_row1a_q[63:32];
	assign m[3] = row0c_row1a_q[31:0];
	assign m[4] = row1_bc_q[63:32];
	assign m[5] = row1_bc_q[31:0];
	assign m[6] = row2_ab_q[63:32];
	assign m[7] = row2_ab_q[31:0];
	assign m[8] = row2_c_q;

	// single stall for the whole pipe, released when the output slot frees
	assign adv           = !tag_out.valid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DLY; i++) tag_d[i] <= '0;
		end else if (adv) begin
			tag_d[0].valid <= s_axis_tvalid;
			tag_d[0].empty <= ($signed(s_axis_tdata[3*CW-1:2*CW]) <= 0) ||
				($signed(s_axis_tdata[4*CW-1:3*CW]) <= 0);
			for (int i = 1; i <= DLY; i++) tag_d[i] <= tag_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s1 <= s_axis_tdata[CW-1:0];
			ry_s1 <= s_axis_tdata[2*CW-1:CW];
			rw_s1 <= s_axis_tdata[3*CW-1:2*CW];
			rh_s1 <= s_axis_tdata[4*CW-1:3*CW];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_corner
		logic signed [PW-1:0] px, py;
		assign px = PW'(rx_s1) + ((k % 2 == 1) ? PW'(rw_s1) : PW'(0));
		assign py = PW'(ry_s1) + ((k / 2 == 1) ? PW'(rh_s1) : PW'(0));

		rhbb_corner #(.PW(PW), .NW(NW), .FRAC(COEF_FRAC_BITS)) u_corner (
			.clk(clk), .en(adv), .px(px), .py(py), .m(m),
			.nx(nx[k]), .ny(ny[k]), .w(wv[k])
		);

		rhbb_div #(.NW(NW)) u_div_x (
			.clk(clk), .en(adv), .n(nx[k]), .d(wv[k]),
			.q_floor(fx[k]), .q_ceil(cx[k])
		);

		rhbb_div #(.NW(NW)) u_div_y (
			.clk(clk), .en(adv), .n(ny[k]), .d(wv[k]),
			.q_floor(fy[k]), .q_ceil(cy[k])
		);
	end

	rhbb_reduce #(.VW(VW)) u_reduce (
		.clk(clk), .arst_n(arst_n), .en(adv), .tag_in(tag_d[DLY]),
		.fx(fx), .cx(cx), .fy(fy), .cy(cy),
		.tag_out(tag_out),
		.box_x(box_x), .box_y(box_y), .box_width(box_width), .box_height(box_height),
		.box_empty(box_empty), .saturated(saturated)
	);

	assign m_axis_tvalid = tag_out.valid;
	assign m_axis_tdata  = {2'b00, box_height, box_width, box_y, box_x};
	assign m_axis_tuser  = {saturated, box_empty};

endmodule
